// ===== hw/rtl/ubxfr_pkg.sv =====
`timescale 1ns / 1ps
package ubxfr_pkg;

   localparam int MAX_PAYLOAD = 128;
   localparam int POS_W = $clog2(MAX_PAYLOAD + 1);

   localparam logic [7:0] SYNC_FIRST    = 8'hB5;
   localparam logic [7:0] SYNC_SECOND   = 8'h62;
   localparam logic [7:0] CLASS_ACK     = 8'h05;
   localparam logic [7:0] ID_ACK        = 8'h01;
   localparam logic [7:0] ID_NACK       = 8'h00;
   localparam logic [7:0] CLASS_NAV     = 8'h01;
   localparam logic [7:0] ID_NAV_PVT    = 8'h07;
   localparam logic [7:0] ID_NAV_POSLLH = 8'h02;

   localparam logic [1:0] HDR_CLASS  = 2'd0;
   localparam logic [1:0] HDR_ID     = 2'd1;
   localparam logic [1:0] HDR_LEN_LO = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_HEADER,
      PH_PAYLOAD,
      PH_CKA,
      PH_CKB
   } phase_type;

   typedef struct packed {
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [7:0]  payload_len;
      logic        checksum_ok;
      logic        is_ack;
      logic        is_nack;
      logic [15:0] good_count;
      logic [15:0] bad_count;
   } result_type;

endpackage

// ===== hw/rtl/ubxfr_parser.sv =====
`timescale 1ns / 1ps
module ubxfr_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  logic [7:0]           byte_data,
   output logic                 res_valid,
   output ubxfr_pkg::result_type res
);
   import ubxfr_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        class_ff, class_in;
   logic [7:0]        id_ff, id_in;
   logic [15:0]       length_ff, length_in;
   logic [7:0]        sum_a_ff, sum_a_in;
   logic [7:0]        sum_b_ff, sum_b_in;
   logic [7:0]        recv_a_ff, recv_a_in;
   logic [15:0]       good_ff, good_in;
   logic [15:0]       bad_ff, bad_in;

   logic [7:0]        add_a;
   logic [7:0]        add_b;
   logic [POS_W-1:0]  pos_inc;
   logic [15:0]       full_len;
   logic              ok;

   assign add_a    = sum_a_ff + byte_data;
   assign add_b    = sum_b_ff + add_a;
   assign pos_inc  = pos_ff + POS_W'(1);
   assign full_len = {byte_data, length_ff[7:0]};
   assign ok       = (recv_a_ff == sum_a_ff) && (byte_data == sum_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT1;
         pos_ff    <= '0;
         class_ff  <= '0;
         id_ff     <= '0;
         length_ff <= '0;
         sum_a_ff  <= '0;
         sum_b_ff  <= '0;
         recv_a_ff <= '0;
         good_ff   <= '0;
         bad_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         class_ff  <= class_in;
         id_ff     <= id_in;
         length_ff <= length_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         recv_a_ff <= recv_a_in;
         good_ff   <= good_in;
         bad_ff    <= bad_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      length_in = length_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      recv_a_in = recv_a_ff;
      good_in   = good_ff;
      bad_in    = bad_ff;
      res_valid = 1'b0;

      if (byte_valid) begin
         case (phase_ff)
            PH_HUNT1: begin
               if (byte_data == SYNC_FIRST) begin
                  phase_in = PH_HUNT2;
               end
            end
            PH_HUNT2: begin
               if (byte_data == SYNC_SECOND) begin
                  phase_in = PH_HEADER;
                  pos_in   = '0;
                  sum_a_in = '0;
                  sum_b_in = '0;
               end else begin
                  phase_in = PH_HUNT1;
               end
            end
            PH_HEADER: begin
               sum_a_in = add_a;
               sum_b_in = add_b;
               pos_in   = pos_inc;
               if (pos_ff == POS_W'(HDR_CLASS)) begin
                  class_in = byte_data;
               end else if (pos_ff == POS_W'(HDR_ID)) begin
                  id_in = byte_data;
               end else if (pos_ff == POS_W'(HDR_LEN_LO)) begin
                  length_in = {8'h00, byte_data};
               end else begin
                  length_in = full_len;
                  pos_in    = '0;
                  if (full_len > 16'(MAX_PAYLOAD)) begin
                     phase_in = PH_HUNT1;
                  end else if (full_len == 16'h0000) begin
                     phase_in = PH_CKA;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               sum_a_in = add_a;
               sum_b_in = add_b;
               pos_in   = pos_inc;
               if (16'(pos_inc) >= length_ff) begin
                  pos_in   = '0;
                  phase_in = PH_CKA;
               end
            end
            PH_CKA: begin
               recv_a_in = byte_data;
               phase_in  = PH_CKB;
            end
            PH_CKB: begin
               res_valid = 1'b1;
               if (!ok) begin
                  bad_in = bad_ff + 16'd1;
               end else if (class_ff == CLASS_NAV &&
                            (id_ff == ID_NAV_PVT || id_ff == ID_NAV_POSLLH)) begin
                  good_in = good_ff + 16'd1;
               end
               phase_in = PH_HUNT1;
               pos_in   = '0;
            end
            default: begin
               phase_in = PH_HUNT1;
               pos_in   = '0;
            end
         endcase
      end

      res.msg_class   = class_ff;
      res.msg_id      = id_ff;
      res.payload_len = length_ff[7:0];
      res.checksum_ok = ok;
      res.is_ack      = ok && class_ff == CLASS_ACK && id_ff == ID_ACK;
      res.is_nack     = ok && class_ff == CLASS_ACK && id_ff == ID_NACK;
      res.good_count  = good_in;
      res.bad_count   = bad_in;
   end

endmodule

// ===== hw/rtl/ubx_frame_receiver.sv =====
`timescale 1ns / 1ps
// sync-framed binary message receiver with 8-bit fletcher checksum
// req channel: one received serial byte per item on req_rx_byte
// rsp channel: one item per completed frame carrying class, id, payload
//    length, checksum verdict, ack/nack flags and the good/bad frame counts
// oversized frames and sync mismatches produce no item
// throughput: one byte per cycle unless rsp_stall holds a waiting result;
//    the running sum and byte position counter use the registered byte
// output path: the second checksum byte passes through the input register,
//    then the result register, before its result appears on rsp_valid
// reset: synchronous, clears the hunt state, sums and both counters, and
//    empties the input and result registers
// when rsp_stall is high with a result waiting, the byte held in the input
//    register waits and req_stall rises; an empty input register still
//    takes in one more byte meanwhile
module ubx_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_msg_class,
   output logic [7:0]  rsp_msg_id,
   output logic [7:0]  rsp_payload_len,
   output logic        rsp_checksum_ok,
   output logic        rsp_is_ack,
   output logic        rsp_is_nack,
   output logic [15:0] rsp_good_count,
   output logic [15:0] rsp_bad_count
);
   import ubxfr_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       advance;
   logic       res_valid;
   result_type res;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   ubxfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (in_valid_ff && advance),
      .byte_data  (in_byte_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_rx_byte;
      end
      if (advance) begin
         out_valid_in = in_valid_ff && res_valid;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_msg_class   = out_ff.msg_class;
   assign rsp_msg_id      = out_ff.msg_id;
   assign rsp_payload_len = out_ff.payload_len;
   assign rsp_checksum_ok = out_ff.checksum_ok;
   assign rsp_is_ack      = out_ff.is_ack;
   assign rsp_is_nack     = out_ff.is_nack;
   assign rsp_good_count  = out_ff.good_count;
   assign rsp_bad_count   = out_ff.bad_count;

endmodule
